>>> hdl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg: shared types and constants for the sorted insertion list
// Request and result codes, the data width and the control word that
// drives every cell in the chain.
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DRAIN  = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        KIND_INSERTED = 3'd0,
        KIND_DROPPED  = 3'd1,
        KIND_DRAINED  = 3'd2,
        KIND_EMPTY    = 3'd3,
        KIND_CLEARED  = 3'd4
    } t_kind;

    // Control word broadcast to all cells in one cycle.
    typedef struct packed {
        logic insert;
        logic rotate;
        logic clear;
    } t_cell_ctrl;

endpackage

>>> hdl/sil_cell.sv
// ----------------------------------------------------------------------------
// sil_cell: one slot of the sorted chain
// Holds one value and its valid bit. On insert it keeps, takes the new value
// or takes its left neighbor's value; on rotate it takes its right neighbor's
// value, or cell zero's when last valid; the chain streams out from cell zero.
// ----------------------------------------------------------------------------
module sil_cell
    import sil_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_prev_entry,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_gt,
    input  logic signed [DATA_W-1:0] i_next_entry,
    input  logic                     i_next_valid,
    input  logic signed [DATA_W-1:0] i_wrap_entry,
    output logic signed [DATA_W-1:0] o_entry,
    output logic                     o_valid,
    output logic                     o_gt
);

    logic signed [DATA_W-1:0] r_entry, n_entry;
    logic                     r_valid, n_valid;
    logic                     w_gt;

    // A stored value strictly above the new one must move right, so equal
    // values keep their arrival order.
    assign w_gt = r_valid && (r_entry > i_value);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.insert) begin
            if (w_gt || (!r_valid && i_prev_valid)) begin
                n_entry = i_prev_gt ? i_prev_entry : i_value;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.rotate) begin
            if (i_next_valid) begin
                n_entry = i_next_entry;
            end else if (r_valid) begin
                n_entry = i_wrap_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_gt    = w_gt;

endmodule

>>> hdl/sorted_insertion_list_core.sv
// ----------------------------------------------------------------------------
// sorted_insertion_list_core: bounded ascending store of signed values
// Insert and clear give their single result in the cycle after acceptance,
// and a new item is taken in every cycle for them. A drain of a non-empty
// store sets the drain flag and holds busy while the result register streams
// one value per cycle, as the chain rotates one slot per cycle. Results cannot
// be stalled by the receiver. Synchronous active-low reset empties the store;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module sorted_insertion_list_core
    import sil_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic [2:0]               o_kind,
    output logic                     o_last
);

    // Count wide enough to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    // The chain. Valid cells always form a prefix starting at cell zero, and
    // outside a drain their values are ascending from left to right.
    logic signed [DATA_W-1:0] w_entry [CAPACITY];
    logic                     w_valid [CAPACITY];
    logic                     w_gt    [CAPACITY];

    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_full;

    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_value, n_out_value;
    t_kind                    r_out_kind, n_out_kind;
    logic                     r_out_last, n_out_last;
    logic                     r_draining, n_draining;
    logic [CW-1:0]            r_remain, n_remain;
    logic [CW-1:0]            r_count, n_count;

    // Items are taken whenever no drain is in progress.
    assign busy     = r_draining;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));

    // Broadcast control for the cells. During a drain the chain rotates so
    // that cell zero presents the next value in ascending order; after
    // count rotations every value is back in its own slot.
    always_comb begin
        w_ctrl.insert = w_accept && (t_req'(i_req_type) == REQ_INSERT) && !w_full;
        w_ctrl.clear  = w_accept && (t_req'(i_req_type) == REQ_CLEAR);
        w_ctrl.rotate = r_draining;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev_entry;
        logic                     w_prev_valid;
        logic                     w_prev_gt;
        logic signed [DATA_W-1:0] w_next_entry;
        logic                     w_next_valid;

        // The head cell sees a virtual neighbor that is valid and not
        // greater, so an empty store places the new value in cell zero.
        if (g == 0) begin : g_head
            assign w_prev_entry = '0;
            assign w_prev_valid = 1'b1;
            assign w_prev_gt    = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_gt    = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_entry = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next_entry = w_entry[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        sil_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (i_value),
            .i_prev_entry (w_prev_entry),
            .i_prev_valid (w_prev_valid),
            .i_prev_gt    (w_prev_gt),
            .i_next_entry (w_next_entry),
            .i_next_valid (w_next_valid),
            .i_wrap_entry (w_entry[0]),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g])
        );
    end

    // Result register and drain sequencing.
    always_comb begin
        n_out_valid = 1'b0;
        n_out_value = '0;
        n_out_kind  = KIND_INSERTED;
        n_out_last  = 1'b1;
        n_draining  = r_draining;
        n_remain    = r_remain;
        n_count     = r_count;

        if (r_draining) begin
            // Cell zero holds the next value of the stream.
            n_out_valid = 1'b1;
            n_out_value = w_entry[0];
            n_out_kind  = KIND_DRAINED;
            n_out_last  = (r_remain == CW'(1));
            n_remain    = r_remain - CW'(1);
            if (r_remain == CW'(1)) begin
                n_draining = 1'b0;
            end
        end else if (w_accept) begin
            case (t_req'(i_req_type))
                REQ_INSERT: begin
                    n_out_valid = 1'b1;
                    if (w_full) begin
                        n_out_kind = KIND_DROPPED;
                    end else begin
                        n_out_kind = KIND_INSERTED;
                        n_count    = r_count + CW'(1);
                    end
                end
                REQ_DRAIN: begin
                    if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_EMPTY;
                    end else begin
                        n_draining = 1'b1;
                        n_remain   = r_count;
                    end
                end
                REQ_CLEAR: begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_CLEARED;
                    n_count     = '0;
                end
                default: begin
                    // The unused request code is taken and has no effect.
                    n_out_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_draining  <= 1'b0;
            r_remain    <= '0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_draining  <= n_draining;
            r_remain    <= n_remain;
            r_count     <= n_count;
        end
        r_out_value <= n_out_value;
        r_out_kind  <= n_out_kind;
        r_out_last  <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_kind      = r_out_kind;
    assign o_last      = r_out_last;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for sorted_insertion_list_core
// Drives insert, drain, clear and unused request items through the start/busy
// handshake, predicts every result from its own ordered copy of the store,
// and compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import sil_pkg::*;

    // Request code 3 is not decoded by the block; it is accepted and ignored.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         N_ITEMS    = 500;
    localparam int         QUIET_TAIL = 80;

    typedef struct {
        logic signed [DATA_W-1:0] out_value;
        t_kind                    kind;
        logic                     last;
    } t_result_item;

    // The predictor keeps the stored values as an ordered queue and turns each
    // accepted request into the list of results the block must produce.
    class sorted_list_predictor;
        logic signed [DATA_W-1:0] stored_values[$];
        t_result_item             expected_results[$];
        int unsigned              mismatches;

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void push_result(logic signed [DATA_W-1:0] v, t_kind k, logic l);
            t_result_item r;
            r.out_value = v;
            r.kind      = k;
            r.last      = l;
            expected_results.push_back(r);
        endfunction

        function void note_request(logic [1:0] req, logic signed [DATA_W-1:0] v);
            int pos;
            case (req)
                REQ_INSERT: begin
                    if (stored_values.size() >= CAPACITY_DEF) begin
                        push_result('0, KIND_DROPPED, 1'b1);
                    end else begin
                        // Equal values keep arrival order: skip past every
                        // stored value that is less than or equal.
                        pos = 0;
                        while (pos < stored_values.size() && stored_values[pos] <= v)
                            pos++;
                        stored_values.insert(pos, v);
                        push_result('0, KIND_INSERTED, 1'b1);
                    end
                end
                REQ_DRAIN: begin
                    if (stored_values.size() == 0) begin
                        push_result('0, KIND_EMPTY, 1'b1);
                    end else begin
                        foreach (stored_values[i])
                            push_result(stored_values[i], KIND_DRAINED,
                                        i == stored_values.size() - 1);
                    end
                end
                REQ_CLEAR: begin
                    stored_values.delete();
                    push_result('0, KIND_CLEARED, 1'b1);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic signed [DATA_W-1:0] v, logic [2:0] k, logic l);
            t_result_item e;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result: value %0d kind %0d last %0b",
                                 v, k, l));
                return;
            end
            e = expected_results.pop_front();
            if (v !== e.out_value || k !== e.kind || l !== e.last) begin
                report($sformatf(
                    "mismatch: expected value %0d kind %0d last %0b, got %0d %0d %0b",
                    e.out_value, e.kind, e.last, v, k, l));
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    logic                     busy;
    logic [1:0]               i_req_type = REQ_INSERT;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_out_value;
    logic [2:0]               o_kind;
    logic                     o_last;

    sorted_list_predictor list_model = new();
    int unsigned          items_sent = 0;
    bit                   gaps_on    = 1'b1;

    sorted_insertion_list_core #(
        .CAPACITY(CAPACITY_DEF)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_out_value(o_out_value),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Both the handshake and the result strobe are sampled at the rising edge,
    // so the values seen here are the ones that were stable during the cycle.
    // A result is always checked before the item of the same edge is noted,
    // because no result can come out in the cycle its item is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                list_model.check_result(o_out_value, o_kind, o_last);
            if (start && !busy)
                list_model.note_request(i_req_type, i_value);
        end
    end

    // Values cluster in a few places so that duplicates, the extremes and
    // values around zero show up often, while full-range values toggle every bit.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 40)) - 20;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shffff_ffff;
                endcase
            end
            default: return $signed($urandom_range(0, 7));
        endcase
    endfunction

    // Presents one item and holds it until the block takes it. Afterwards the
    // sender may pause for a short burst, which lands on whatever phase of
    // work the block happens to be in, including the middle of a drain.
    task automatic send_item(input logic [1:0] req, input logic signed [DATA_W-1:0] v);
        int gap;
        start      <= 1'b1;
        i_req_type <= req;
        i_value    <= v;
        do
            @(posedge i_clk);
        while (busy);
        if (req != REQ_UNUSED)
            items_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            start      <= 1'b0;
            i_req_type <= 2'($urandom);
            i_value    <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic insert_run(input int n);
        repeat (n) send_item(REQ_INSERT, pick_value());
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty drain, both extremes, a value equal to the
        // current maximum, duplicates, an unused request code, clear on an
        // empty store and a drain of a single value.
        send_item(REQ_DRAIN,  $urandom);
        send_item(REQ_INSERT, 32'sh7fff_ffff);
        send_item(REQ_INSERT, 32'sh7fff_ffff);
        send_item(REQ_INSERT, 32'sh8000_0000);
        send_item(REQ_INSERT, 32'sh0000_0000);
        send_item(REQ_INSERT, 32'shffff_ffff);
        send_item(REQ_INSERT, 32'sh0000_0000);
        send_item(REQ_INSERT, 32'sh0000_0001);
        send_item(REQ_INSERT, 32'sh8000_0000);
        send_item(REQ_DRAIN,  32'sh7fff_ffff);
        send_item(REQ_UNUSED, 32'sh5555_5555);
        send_item(REQ_UNUSED, 32'shaaaa_aaaa);
        send_item(REQ_DRAIN,  32'sh8000_0000);
        send_item(REQ_CLEAR,  32'shffff_ffff);
        send_item(REQ_DRAIN,  '0);
        send_item(REQ_CLEAR,  '0);
        send_item(REQ_INSERT, 32'sh0000_0005);
        send_item(REQ_DRAIN,  '0);

        // Random part. Most traffic is a fill, mostly after a clear, followed by a
        // drain; a quarter of the fills come close to or run past capacity so that
        // dropped inserts and full-length drains come up regularly.
        while (items_sent < N_ITEMS) begin
            gaps_on = (items_sent < N_ITEMS - QUIET_TAIL);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if ($urandom_range(0, 3) != 0)
                        send_item(REQ_CLEAR, $urandom);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 36)
                                                    : $urandom_range(0, 12);
                    insert_run(n);
                    send_item(REQ_DRAIN, $urandom);
                end
                6: begin
                    insert_run($urandom_range(1, 4));
                    send_item(REQ_DRAIN, $urandom);
                end
                7: begin
                    repeat ($urandom_range(1, 5))
                        send_item(2'($urandom), $urandom);
                end
                8: begin
                    send_item(REQ_DRAIN, $urandom);
                    send_item(REQ_DRAIN, $urandom);
                end
                default: begin
                    send_item(REQ_CLEAR, $urandom);
                    send_item(REQ_DRAIN, $urandom);
                end
            endcase
        end
        start <= 1'b0;

        // Let every predicted result drain out, then watch a little longer
        // for anything the block should not have produced.
        while (list_model.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (CAPACITY_DEF + 8) @(posedge i_clk);

        if (list_model.mismatches == 0) begin
            $display("sorted_insertion_list_core regression: pass");
        end else begin
            $display("sorted_insertion_list_core regression: fail");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run: every item waiting out a
    // full-length drain plus the longest sender pause.
    initial begin
        #400000;
        $display("sorted_insertion_list_core regression: fail");
        $finish;
    end

endmodule

>>> sorted_insertion_list_core.f
hdl/sil_pkg.sv
hdl/sil_cell.sv
hdl/sorted_insertion_list_core.sv
dv/tb_top.sv
